@@ hw/rtl/fwbp_pkg.sv @@
// Shared constants and types of the fixed-width bit packer.
package fwbp_pkg;

  localparam int WIDTH_W = 7;   // pack width register and remaining-bit counters
  localparam int BYTE_W  = 8;
  localparam int FILL_W  = 3;   // bits held in the partial byte, 0..7

  localparam logic [WIDTH_W-1:0] PACK_BITS_RESET = 7'd8;

  // Control half of a queued item.
  typedef struct packed {
    logic               last;
    logic [WIDTH_W-1:0] width;
  } item_ctrl_t;

  // Queue occupancy seen by the front and the back.
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

  // Back-end status brought out for checking.
  typedef struct packed {
    logic              out_last_held;
    logic [FILL_W-1:0] fill;
  } pk_stat_t;

endpackage

@@ hw/rtl/fwbp_ifs.sv @@
// Channel interfaces: input values, packed bytes, pack width writes.
interface fwbp_in_if #(parameter int VALUE_WIDTH = 64);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last_value;

  modport source (output valid, output value, output last_value, input ready);
  modport sink   (input valid, input value, input last_value, output ready);
endinterface

interface fwbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       last_byte;

  modport source (output valid, output byte_out, output last_byte, input ready);
  modport sink   (input valid, input byte_out, input last_byte, output ready);
endinterface

interface fwbp_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] pack_bits;

  modport source (output valid, output pack_bits, input ready);
  modport sink   (input valid, input pack_bits, output ready);
endinterface

@@ hw/rtl/fwbp_front.sv @@
// Front end: pack width register, width clamp, value alignment and queue push.
module fwbp_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  fwbp_in_if.sink                in_ch,
  fwbp_cfg_if.sink               cfg_ch,
  input  fwbp_pkg::q_stat_t      q_stat,
  output logic                   push,
  output fwbp_pkg::item_ctrl_t   push_ctrl,
  output logic [VALUE_WIDTH-1:0] push_data
);
  import fwbp_pkg::*;

  localparam logic [WIDTH_W-1:0] VW = WIDTH_W'(VALUE_WIDTH);

  logic [WIDTH_W-1:0] pack_bits_r;
  logic [WIDTH_W-1:0] pack_bits_nxt;
  logic [WIDTH_W-1:0] w_eff;
  logic [WIDTH_W-1:0] shamt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    pack_bits_nxt = pack_bits_r;
    if (cfg_ch.valid) begin
      pack_bits_nxt = cfg_ch.pack_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_bits_r <= PACK_BITS_RESET;
    end else begin
      pack_bits_r <= pack_bits_nxt;
    end
  end

  // Left-align so the first bit sits at the MSB; the shift also drops unused high bits.
  assign w_eff = (pack_bits_r > VW) ? VW : pack_bits_r;
  assign shamt = VW - w_eff;

  assign in_ch.ready     = !q_stat.full;
  assign push            = in_ch.valid && !q_stat.full;
  assign push_ctrl.last  = in_ch.last_value;
  assign push_ctrl.width = w_eff;
  assign push_data       = in_ch.value << shamt;

endmodule

@@ hw/rtl/fwbp_queue.sv @@
// Two-entry queue between front and back end.
module fwbp_queue #(
  parameter int DATA_W = 72
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output fwbp_pkg::q_stat_t stat
);
  import fwbp_pkg::*;

  logic [DATA_W-1:0] mem [2];
  logic              wr_ptr_r, wr_ptr_nxt;
  logic              rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data   = mem[rd_ptr_r];
  assign stat.full  = count_r[1];
  assign stat.valid = (count_r != 2'd0);

endmodule

@@ hw/rtl/fwbp_back.sv @@
// Back end: shifts aligned values into the partial byte and emits bytes.
module fwbp_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  fwbp_pkg::q_stat_t      q_stat,
  input  fwbp_pkg::item_ctrl_t   pop_ctrl,
  input  logic [VALUE_WIDTH-1:0] pop_data,
  output logic                   pop,
  fwbp_out_if.source             out_ch,
  output fwbp_pkg::pk_stat_t     stat
);
  import fwbp_pkg::*;

  logic                   active_r, active_nxt;
  logic [VALUE_WIDTH-1:0] sr_r, sr_nxt;
  logic [WIDTH_W-1:0]     rem_r, rem_nxt;
  logic                   last_r, last_nxt;
  logic [BYTE_W-1:0]      partial_r, partial_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0]      out_byte_r, out_byte_nxt;
  logic                   out_last_r, out_last_nxt;

  logic                   can_emit;
  logic [WIDTH_W-1:0]     total;
  logic [3:0]             take;
  logic [BYTE_W-1:0]      merged;

  assign can_emit = !out_valid_r || out_ch.ready;
  assign total    = WIDTH_W'(fill_r) + rem_r;
  assign take     = 4'd8 - 4'(fill_r);
  assign merged   = partial_r | (sr_r[VALUE_WIDTH-1 -: BYTE_W] >> fill_r);
  assign pop      = !active_r && q_stat.valid;

  always_comb begin
    active_nxt    = active_r;
    sr_nxt        = sr_r;
    rem_nxt       = rem_r;
    last_nxt      = last_r;
    partial_nxt   = partial_r;
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (pop) begin
      active_nxt = 1'b1;
      sr_nxt     = pop_data;
      rem_nxt    = pop_ctrl.width;
      last_nxt   = pop_ctrl.last;
    end else if (active_r && can_emit) begin
      if (total >= WIDTH_W'(BYTE_W)) begin
        // byte completes: emit it, keep going while value bits remain
        out_valid_nxt = 1'b1;
        out_byte_nxt  = merged;
        out_last_nxt  = last_r && (total == WIDTH_W'(BYTE_W));
        sr_nxt        = sr_r << take;
        rem_nxt       = rem_r - WIDTH_W'(take);
        partial_nxt   = '0;
        fill_nxt      = '0;
        active_nxt    = (rem_nxt != '0);
      end else begin
        active_nxt = 1'b0;
        if (last_r && total != '0) begin
          // flush zero-padded partial byte
          out_valid_nxt = 1'b1;
          out_byte_nxt  = merged;
          out_last_nxt  = 1'b1;
          partial_nxt   = '0;
          fill_nxt      = '0;
        end else begin
          partial_nxt = merged;
          fill_nxt    = total[FILL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      partial_r   <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      partial_r   <= partial_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r       <= sr_nxt;
    rem_r      <= rem_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.byte_out    = out_byte_r;
  assign out_ch.last_byte   = out_last_r;
  assign stat.out_last_held = out_valid_r && out_last_r;
  assign stat.fill          = fill_r;

endmodule

@@ hw/rtl/fixed_width_bit_packer_core.sv @@
// Fixed-width bit packer, MSB first: top level joining front, queue and back end.
// The first byte of an item passes through the queue, the load into the back-end shift
//   register and the output register. Throughput: one byte per cycle from the output
//   register while out_ch.ready is high; each item also takes a load step, and a further
//   step when it leaves only a partial byte to hold.
// Reset (rst_n low, synchronous): pack width = 8, partial byte and queue emptied.
module fixed_width_bit_packer_core #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  fwbp_in_if.sink     in_ch,
  fwbp_out_if.source  out_ch,
  fwbp_cfg_if.sink    cfg_ch
);
  import fwbp_pkg::*;

  localparam int Q_W = VALUE_WIDTH + $bits(item_ctrl_t);

  q_stat_t                q_stat;
  pk_stat_t               pk_stat;
  logic                   q_push;
  logic                   q_pop;
  item_ctrl_t             push_ctrl;
  item_ctrl_t             pop_ctrl;
  logic [VALUE_WIDTH-1:0] push_data;
  logic [VALUE_WIDTH-1:0] pop_data;
  logic [Q_W-1:0]         q_out;

  fwbp_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_ctrl (push_ctrl),
    .push_data (push_data)
  );

  fwbp_queue #(.DATA_W(Q_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data ({push_ctrl, push_data}),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  assign pop_ctrl = q_out[Q_W-1 -: $bits(item_ctrl_t)];
  assign pop_data = q_out[VALUE_WIDTH-1:0];

  fwbp_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .pop_ctrl (pop_ctrl),
    .pop_data (pop_data),
    .pop      (q_pop),
    .out_ch   (out_ch),
    .stat     (pk_stat)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.valid)
    else $error("queue pop while empty");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pk_stat.out_last_held |-> (pk_stat.fill == '0))
    else $error("bits held while end-of-run byte pending");
`endif

endmodule

@@ test/tb_fixed_width_bit_packer_core.sv @@
// Testbench for fixed_width_bit_packer_core: directed and random runs against a bit-level predictor.
`timescale 1ns / 100ps

module tb_fixed_width_bit_packer_core;
  import fwbp_pkg::*;

  localparam int VW          = 64;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 30;   // covers queue + load + emit with margin
  localparam int RANDOM_ITEMS = 65;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              fin;
  } packed_byte_t;

  logic clk;
  logic rst_n;

  fwbp_in_if #(.VALUE_WIDTH(VW)) in_ch();
  fwbp_out_if                    out_ch();
  fwbp_cfg_if                    cfg_ch();

  fixed_width_bit_packer_core #(.VALUE_WIDTH(VW)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state
  logic [WIDTH_W-1:0] pack_width;
  logic [BYTE_W-1:0]  held_bits;
  int                 held_cnt;
  packed_byte_t       expected_bytes[$];

  int  err_count;
  bit  idle_on;
  int  hold_asked;
  int  items_sent;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    else return $urandom_range(10, 40);
  endfunction

  function automatic logic [VW-1:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return '1;
      1:       return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int eff_width();
    return (int'(pack_width) > VW) ? VW : int'(pack_width);
  endfunction

  // Shift the low bits of v into the held byte MSB first; queue each full byte, and on fin the padded rest.
  function automatic void pack_value(input logic [VW-1:0] v, input logic fin);
    packed_byte_t step_q[$];
    packed_byte_t pb;
    for (int i = eff_width(); i > 0; i--) begin
      held_bits[7 - held_cnt] = v[i-1];
      held_cnt++;
      if (held_cnt == BYTE_W) begin
        pb.data = held_bits;
        pb.fin  = 1'b0;
        step_q.push_back(pb);
        held_bits = '0;
        held_cnt  = 0;
      end
    end
    if (fin) begin
      if (held_cnt != 0) begin
        pb.data = held_bits;
        pb.fin  = 1'b0;
        step_q.push_back(pb);
      end
      // end flag only if this beat produced something
      if (step_q.size() > 0) step_q[step_q.size()-1].fin = 1'b1;
      held_bits = '0;
      held_cnt  = 0;
    end
    foreach (step_q[k]) expected_bytes.push_back(step_q[k]);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  always @(posedge clk) begin : byte_checker
    packed_byte_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last=%0b",
                                  out_ch.byte_out, out_ch.last_byte));
      end else begin
        want = expected_bytes.pop_front();
        if (out_ch.byte_out !== want.data)
          report_mismatch($sformatf("byte_out %02h, want %02h", out_ch.byte_out, want.data));
        if (out_ch.last_byte !== want.fin)
          report_mismatch($sformatf("last_byte %0b, want %0b on byte %02h",
                                    out_ch.last_byte, want.fin, want.data));
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  initial begin : rx_ready
    int stall_left;
    int hold_left;
    int hold_granted;
    stall_left   = 0;
    hold_left    = 0;
    hold_granted = 0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_granted != hold_asked) begin
        hold_granted = hold_asked;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < 25) begin
        stall_left = pick_gap() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic send_value(input logic [VW-1:0] v, input logic fin);
    int gap;
    if (idle_on && $urandom_range(0, 1) == 1) begin
      gap = pick_gap();
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value      <= v;
    in_ch.last_value <= fin;
    do @(posedge clk); while (!in_ch.ready);
    pack_value(v, fin);
    if (eff_width() > 0) items_sent++;
  endtask

  task automatic stop_sending();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] w);
    stop_sending();
    wait_drained();
    // items that emit nothing may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.pack_bits <= w;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    pack_width = w;
  endtask

  task automatic test_reset_width();
    idle_on = 1'b0;
    send_value(64'hFFFF_FFFF_FFFF_FF5A, 1'b0);   // upper bits must be masked
    send_value(64'h0, 1'b0);
    send_value(64'h81, 1'b1);
  endtask

  task automatic test_single_bit();
    write_width(7'd1);
    send_value(64'h1, 1'b0);
    send_value(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
    send_value(64'h1, 1'b0);
    send_value('1, 1'b0);
    send_value(64'h0, 1'b1);                     // 5 bits held, flushed padded
  endtask

  task automatic test_full_width();
    idle_on = 1'b1;
    write_width(7'd64);
    send_value('1, 1'b0);
    send_value('0, 1'b0);
    send_value(64'hDEAD_BEEF_0123_4567, 1'b1);
  endtask

  task automatic test_saturated_width();
    write_width(7'd3);
    send_value(64'h5, 1'b0);                     // three bits held
    write_width(7'd127);
    send_value('1, 1'b1);                        // 67 bits: nine bytes
    write_width(7'd65);
    send_value(64'h8000_0000_0000_0001, 1'b1);
  endtask

  task automatic test_zero_width();
    write_width(7'd5);
    send_value(64'h15, 1'b0);
    write_width(7'd0);
    send_value('1, 1'b0);                        // packs nothing
    send_value('1, 1'b1);                        // flushes the held five bits
    send_value('1, 1'b1);                        // nothing held: no byte at all
  endtask

  task automatic test_aligned_last();
    write_width(7'd4);
    send_value(64'hA, 1'b0);
    send_value(64'h3, 1'b1);                     // ends on a byte boundary
    write_width(7'd12);
    send_value(64'hABC, 1'b0);
    send_value(64'h123, 1'b1);
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    write_width(7'd64);
    hold_asked++;
    for (int i = 0; i < 40; i++) send_value(rand_value(), (i % 5) == 4);
    idle_on = 1'b1;
  endtask

  task automatic test_random_runs();
    int pick;
    int runs;
    int len;
    logic [WIDTH_W-1:0] w;
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      w = WIDTH_W'($urandom_range(1, 16));
      else if (pick < 85) w = WIDTH_W'($urandom_range(17, 64));
      else if (pick < 95) w = WIDTH_W'($urandom_range(65, 127));
      else                w = '0;
      write_width(w);
      idle_on = ($urandom_range(0, 3) != 0);
      runs = $urandom_range(1, 3);
      for (int r = 0; r < runs; r++) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          send_value(rand_value(), (k == len - 1) || ($urandom_range(0, 19) == 0));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    err_count  = 0;
    idle_on    = 1'b0;
    hold_asked = 0;
    items_sent = 0;
    pack_width = PACK_BITS_RESET;
    held_bits  = '0;
    held_cnt   = 0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.value      <= '0;
    in_ch.last_value <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.pack_bits <= PACK_BITS_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_width();
    test_single_bit();
    test_full_width();
    test_saturated_width();
    test_zero_width();
    test_aligned_last();
    test_backpressure();
    test_random_runs();

    stop_sending();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/fwbp_pkg.sv
hw/rtl/fwbp_ifs.sv
hw/rtl/fwbp_front.sv
hw/rtl/fwbp_queue.sv
hw/rtl/fwbp_back.sv
hw/rtl/fixed_width_bit_packer_core.sv
test/tb_fixed_width_bit_packer_core.sv
